### rtl/rwaf_pkg.sv
package rwaf_pkg;

  // Field widths
  localparam int unsigned DBM_W  = 8;
  localparam int unsigned AVG_W  = 12;
  localparam int unsigned CNT_OW = 7;

  // Stream word widths
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned S_TUSER_W = 1;
  localparam int unsigned M_TDATA_W = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_VALID_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_MAX = 1'b1;

  localparam logic signed [DBM_W-1:0] VALID_MIN_RST = -8'sd100;
  localparam logic signed [DBM_W-1:0] VALID_MAX_RST = 8'sd0;

  // Command codes carried in tuser
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  // Result word, lowest bit last
  typedef struct packed {
    logic [M_TDATA_W-30-1:0]    pad;
    logic                       err_window_empty;
    logic                       err_scan_failed;
    logic                       err_not_found;
    logic [CNT_OW-1:0]          stored_count;
    logic signed [AVG_W-1:0]    average_x10;
    logic signed [DBM_W-1:0]    reported_dbm;
  } result_t;

endpackage

### rtl/rwaf_ram.sv
module rwaf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/rssi_window_average_filter_core.sv
// Moving average of accepted signal-strength readings. A measure word (tuser = 0) carries a
// signed dBm reading with found / scan-failed flags; the reading enters a ring of WINDOW entries
// in a single-port-write RAM only when the scan succeeded, the target was found and the reading
// lies within [valid_min_dbm, valid_max_dbm]. Each measure returns one result word: the reported
// reading, ten times the mean of the stored readings truncated toward zero, the fill count and
// the error flags. A clear word (tuser = 1) empties the window and returns nothing.
// One item is processed at a time. A measure that leaves the window empty goes straight to
// loading its result. Otherwise it sweeps the ring (one RAM read per stored reading), then
// runs the restoring divider at one quotient bit per cycle (13 + clog2(WINDOW) bits, 14 for
// a one-entry window), then loads the result once the previous result has left the output
// register. The input is ready again the cycle after the load.
module rssi_window_average_filter_core #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: reading_dbm[7:0], target_found[8], scan_failed[9], zero pad[15:10]
  input  logic [rwaf_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // tuser: cmd[0]
  input  logic [rwaf_pkg::S_TUSER_W-1:0]      s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: reported_dbm[7:0], average_x10[19:8], stored_count[26:20], err_not_found[27],
  //        err_scan_failed[28], err_window_empty[29], zero pad[31:30]
  output logic [rwaf_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic [rwaf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rwaf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = 9 + PTR_W;
  localparam int unsigned DIV_W  = SUM_W + 4;
  localparam int unsigned STEP_W = $clog2(DIV_W + 1);
  localparam int unsigned DBM_W  = rwaf_pkg::DBM_W;
  localparam int unsigned AVG_W  = rwaf_pkg::AVG_W;

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(WINDOW);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  // Configuration registers
  logic signed [DBM_W-1:0] valid_min_q, valid_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_min_q <= rwaf_pkg::VALID_MIN_RST;
      valid_max_q <= rwaf_pkg::VALID_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rwaf_pkg::CFG_VALID_MIN: valid_min_q <= cfg_data_i;
        rwaf_pkg::CFG_VALID_MAX: valid_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input word fields
  logic signed [DBM_W-1:0] in_reading;
  logic                    in_found, in_failed, in_cmd;

  assign in_reading = s_axis_tdata[DBM_W-1:0];
  assign in_found   = s_axis_tdata[DBM_W];
  assign in_failed  = s_axis_tdata[DBM_W+1];
  assign in_cmd     = s_axis_tuser[0];

  // Control and window state
  logic [1:0]              state_q, state_d;
  logic [PTR_W-1:0]        wptr_q, wptr_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [DBM_W-1:0] last_q, last_d;
  logic [CNT_W-1:0]        iss_q, iss_d;
  logic                    rvld_q, rvld_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [DIV_W-1:0]        quo_q, quo_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic                    neg_q, neg_d;
  // Per-item flags
  logic signed [DBM_W-1:0] rep_q, rep_d;
  logic                    nf_q, nf_d, sf_q, sf_d;
  // Output register
  rwaf_pkg::result_t       out_q, out_d;
  logic                    out_vld_q, out_vld_d;

  // RAM interface
  logic                    ram_we, ram_re;
  logic [DBM_W-1:0]        ram_rdata;

  // Datapath helpers
  logic                    accept, do_store;
  logic signed [SUM_W+3:0] sum_ext, prod;
  logic [DIV_W-1:0]        prod_mag;
  logic [CNT_W:0]          rem_sh;
  logic                    rem_ge;
  logic signed [AVG_W-1:0] quo_trunc;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign do_store      = accept && (in_cmd == rwaf_pkg::CMD_MEASURE) && !in_failed &&
                         in_found && (in_reading >= valid_min_q) &&
                         (in_reading <= valid_max_q);

  assign ram_we = do_store;
  assign ram_re = (state_q == ST_SUM) && (iss_q != cnt_q);

  rwaf_ram #(
    .WIDTH (DBM_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wptr_q),
    .wdata_i (in_reading),
    .re_i    (ram_re),
    .raddr_i (iss_q[PTR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Times ten as shift-add, then magnitude for the unsigned divider
  assign sum_ext  = {{4{sum_q[SUM_W-1]}}, sum_q};
  assign prod     = (sum_ext <<< 3) + (sum_ext <<< 1);
  assign prod_mag = prod[SUM_W+3] ? DIV_W'(-prod) : DIV_W'(prod);

  // One restoring step
  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, cnt_q});

  assign quo_trunc = quo_q[AVG_W-1:0];

  always_comb begin
    state_d   = state_q;
    wptr_d    = wptr_q;
    cnt_d     = cnt_q;
    last_d    = last_q;
    iss_d     = iss_q;
    rvld_d    = 1'b0;
    sum_d     = sum_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    step_d    = step_q;
    neg_d     = neg_q;
    rep_d     = rep_q;
    nf_d      = nf_q;
    sf_d      = sf_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;

    // Drop the result once it is taken
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == rwaf_pkg::CMD_CLEAR) begin
            wptr_d = '0;
            cnt_d  = '0;
            last_d = '0;
          end else begin
            rep_d = (!in_failed && in_found) ? in_reading : last_q;
            nf_d  = !in_failed && !in_found;
            sf_d  = in_failed;
            if (do_store) begin
              wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
              cnt_d  = (cnt_q == CNT_FULL) ? cnt_q : cnt_q + 1'b1;
              last_d = in_reading;
            end
            iss_d = '0;
            sum_d = '0;
            if (cnt_d == '0) begin
              quo_d   = '0;
              neg_d   = 1'b0;
              state_d = ST_FIN;
            end else begin
              state_d = ST_SUM;
            end
          end
        end
      end

      // Sweep the ring: issue one read a cycle, accumulate each returned word in the following cycle
      ST_SUM: begin
        if (ram_re) begin
          iss_d  = iss_q + 1'b1;
          rvld_d = 1'b1;
        end
        if (rvld_q) begin
          sum_d = sum_q + {{(SUM_W-DBM_W){ram_rdata[DBM_W-1]}}, ram_rdata};
        end
        if (!ram_re && !rvld_q) begin
          quo_d   = prod_mag;
          neg_d   = prod[SUM_W+3];
          rem_d   = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end
      end

      // Advance one quotient bit per cycle
      ST_DIV: begin
        rem_d  = rem_ge ? CNT_W'(rem_sh - {1'b0, cnt_q}) : rem_sh[CNT_W-1:0];
        quo_d  = {quo_q[DIV_W-2:0], rem_ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_LAST) begin
          state_d = ST_FIN;
        end
      end

      // Hold until the output register is free, then load it
      ST_FIN: begin
        if (!out_vld_q || m_axis_tready) begin
          out_d.pad              = '0;
          out_d.reported_dbm     = rep_q;
          out_d.average_x10      = neg_q ? -quo_trunc : quo_trunc;
          out_d.stored_count     = rwaf_pkg::CNT_OW'(cnt_q);
          out_d.err_not_found    = nf_q;
          out_d.err_scan_failed  = sf_q;
          out_d.err_window_empty = (cnt_q == '0);
          out_vld_d              = 1'b1;
          state_d                = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wptr_q    <= '0;
      cnt_q     <= '0;
      last_q    <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wptr_q    <= wptr_d;
      cnt_q     <= cnt_d;
      last_q    <= last_d;
      rvld_q    <= rvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    iss_q  <= iss_d;
    sum_q  <= sum_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    neg_q  <= neg_d;
    rep_q  <= rep_d;
    nf_q   <= nf_d;
    sf_q   <= sf_d;
    out_q  <= out_d;
  end

  assign m_axis_tdata  = out_q;
  assign m_axis_tvalid = out_vld_q;

endmodule

### tb/sv/rssi_window_average_filter_core_tb.sv
module rssi_window_average_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN        = 8;
  localparam int SETTLE_CYC = 40;
  localparam int HOLD_CYC   = 400;
  localparam int LIMIT_CYC  = 1000000;
  localparam int RAND_ITEMS = 450;     // per idling phase

  localparam int DBM_W      = rwaf_pkg::DBM_W;
  localparam int AVG_W      = rwaf_pkg::AVG_W;
  localparam int CNT_OW     = rwaf_pkg::CNT_OW;
  localparam int S_TDATA_W  = rwaf_pkg::S_TDATA_W;
  localparam int S_TUSER_W  = rwaf_pkg::S_TUSER_W;
  localparam int M_TDATA_W  = rwaf_pkg::M_TDATA_W;
  localparam int CFG_IDX_W  = rwaf_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = rwaf_pkg::CFG_DATA_W;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Window tracking state
  logic signed [DBM_W-1:0] win_ring [WIN];
  int                      win_wptr;
  int                      win_fill;
  logic signed [DBM_W-1:0] win_last;
  logic signed [DBM_W-1:0] lim_min;
  logic signed [DBM_W-1:0] lim_max;
  rwaf_pkg::result_t       avg_expected_q [$];

  int mismatches   = 0;
  int cycles       = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int hold_len     = 0;

  rssi_window_average_filter_core #(
    .WINDOW(WIN)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYC) begin
      $display("** rssi_window_average_filter_core: FAILED **");
      $finish;
    end
  end

  // Drive result ready: long hold when requested, else random stalls
  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      m_axis_tready <= 1'b0;
      hold_len      <= hold_len - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  function automatic void window_clear();
    for (int i = 0; i < WIN; i++) win_ring[i] = '0;
    win_wptr = 0;
    win_fill = 0;
    win_last = '0;
  endfunction

  // Advance the window for one accepted word and queue the expected result
  function automatic void track_window(input logic cmd, input logic signed [DBM_W-1:0] rd,
                                       input logic fnd, input logic fld);
    rwaf_pkg::result_t res;
    int                sum;
    if (cmd == rwaf_pkg::CMD_CLEAR) begin
      window_clear();
      return;
    end
    res              = '0;
    res.reported_dbm = win_last;
    if (!fld) begin
      if (fnd) res.reported_dbm = rd;
      else res.err_not_found = 1'b1;
    end
    res.err_scan_failed = fld;
    if (!fld && fnd && rd >= lim_min && rd <= lim_max) begin
      win_ring[win_wptr] = rd;
      win_wptr = (win_wptr + 1) % WIN;
      if (win_fill < WIN) win_fill++;
      win_last = rd;
    end
    sum = 0;
    for (int i = 0; i < win_fill; i++) sum += 10 * int'(win_ring[i]);
    res.stored_count     = CNT_OW'(win_fill);
    res.err_window_empty = (win_fill == 0);
    res.average_x10      = (win_fill == 0) ? '0 : AVG_W'(sum / win_fill);
    avg_expected_q.push_back(res);
  endfunction

  function automatic bit field_match(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v)
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    return exp_v == act_v;
  endfunction

  // Check each result word against the oldest expectation
  always @(posedge clk_i) begin : chk
    rwaf_pkg::result_t got;
    rwaf_pkg::result_t want;
    bit                ok;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (avg_expected_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = avg_expected_q.pop_front();
        ok = 1'b1;
        ok &= field_match("reported_dbm", int'(want.reported_dbm), int'(got.reported_dbm));
        ok &= field_match("average_x10", int'(want.average_x10), int'(got.average_x10));
        ok &= field_match("stored_count", int'(want.stored_count), int'(got.stored_count));
        ok &= field_match("err_not_found", int'(want.err_not_found), int'(got.err_not_found));
        ok &= field_match("err_scan_failed", int'(want.err_scan_failed),
                          int'(got.err_scan_failed));
        ok &= field_match("err_window_empty", int'(want.err_window_empty),
                          int'(got.err_window_empty));
        if (!ok) mismatches++;
      end
    end
  end

  // Offer one word, with an optional gap first, and hold it until taken
  task automatic send_word(input logic cmd, input logic signed [DBM_W-1:0] rd,
                           input logic fnd, input logic fld);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(S_TDATA_W-DBM_W-2){1'b0}}, fld, fnd, rd};
    do @(posedge clk_i); while (!s_axis_tready);
    track_window(cmd, rd, fnd, fld);
  endtask

  task automatic measure(input logic signed [DBM_W-1:0] rd, input logic fnd, input logic fld);
    send_word(rwaf_pkg::CMD_MEASURE, rd, fnd, fld);
  endtask

  // Drop valid, wait for every result, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (avg_expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_limits(input logic signed [DBM_W-1:0] lo, input logic signed [DBM_W-1:0] hi);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= rwaf_pkg::CFG_VALID_MIN;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i  <= rwaf_pkg::CFG_VALID_MAX;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lim_min = lo;
    lim_max = hi;
  endtask

  // Range edges, error flags and the scan-failure priority at reset limits
  task automatic test_reset_limits();
    measure(-8'sd50, 1'b1, 1'b0);
    measure(-8'sd100, 1'b1, 1'b0);
    measure(8'sd0, 1'b1, 1'b0);
    measure(-8'sd101, 1'b1, 1'b0);
    measure(8'sd1, 1'b1, 1'b0);
    measure(8'sd5, 1'b0, 1'b0);
    measure(-8'sd20, 1'b1, 1'b1);
    measure(-8'sd20, 1'b0, 1'b1);
  endtask

  // Empty the window, then overfill it so the oldest entries are overwritten
  task automatic test_clear_and_wrap();
    send_word(rwaf_pkg::CMD_CLEAR, 8'sh7f, 1'b1, 1'b1);
    measure(-8'sd7, 1'b0, 1'b0);
    for (int i = 1; i <= WIN + 1; i++) measure(-8'(i), 1'b1, 1'b0);
  endtask

  // Widest, inverted and single-point acceptance ranges
  task automatic test_limit_extremes();
    set_limits(-8'sd128, 8'sd127);
    measure(-8'sd128, 1'b1, 1'b0);
    measure(8'sd127, 1'b1, 1'b0);
    measure(8'sd127, 1'b1, 1'b0);
    set_limits(8'sd5, -8'sd5);
    measure(8'sd0, 1'b1, 1'b0);
    set_limits(8'sd127, 8'sd127);
    measure(8'sd127, 1'b1, 1'b0);
    measure(8'sd126, 1'b1, 1'b0);
    set_limits(-8'sd128, -8'sd128);
    measure(-8'sd128, 1'b1, 1'b0);
  endtask

  // Mostly accepted readings; the rest clears, misses, failures and noise
  task automatic random_items(input int count);
    int                      pick;
    logic signed [DBM_W-1:0] rd;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      rd   = DBM_W'($urandom_range(255));
      if (pick < 3)
        send_word(rwaf_pkg::CMD_CLEAR, rd, 1'($urandom_range(1)), 1'($urandom_range(1)));
      else if (pick < 9)
        measure(rd, 1'($urandom_range(1)), 1'b1);
      else if (pick < 15)
        measure(rd, 1'b0, 1'b0);
      else if (pick < 25 || lim_min > lim_max)
        measure(rd, 1'b1, 1'b0);
      else
        measure(DBM_W'(int'(lim_min) +
                       int'($urandom_range(int'(lim_max) - int'(lim_min)))), 1'b1, 1'b0);
    end
  endtask

  // Random items over each idling mix and a spread of limits
  task automatic test_random_phases();
    set_limits(-8'sd100, 8'sd0);
    src_idle_pct = 0;  snk_stall_pct = 0;
    random_items(RAND_ITEMS);
    set_limits(-8'sd128, 8'sd127);
    src_idle_pct = 52; snk_stall_pct = 0;
    random_items(RAND_ITEMS);
    set_limits(-8'sd90, -8'sd30);
    src_idle_pct = 0;  snk_stall_pct = 52;
    random_items(RAND_ITEMS);
    set_limits(-8'sd128, 8'sd127);
    src_idle_pct = 38; snk_stall_pct = 38;
    random_items(RAND_ITEMS);
  endtask

  // Hold the result side off while words keep coming, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_len <= HOLD_CYC;
    random_items(20);
  endtask

  initial begin
    window_clear();
    lim_min = rwaf_pkg::VALID_MIN_RST;
    lim_max = rwaf_pkg::VALID_MAX_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_limits();
    test_clear_and_wrap();
    test_limit_extremes();
    test_random_phases();
    test_backpressure();
    wait_idle();
    if (mismatches == 0) begin
      $display("** rssi_window_average_filter_core: PASSED **");
    end else begin
      $display("** rssi_window_average_filter_core: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/rwaf_pkg.sv
rtl/rwaf_ram.sv
rtl/rssi_window_average_filter_core.sv
tb/sv/rssi_window_average_filter_core_tb.sv
